@@ rtl/ffha_pkg.sv @@
// Package for the first-fit heap allocator.
// Holds the block table entry type, status and register codes, and the controller
// command set. Depends on nothing.
package ffha_pkg;

   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int HEADER_BYTES_DEF = 12;

   localparam logic [31:0] HEAP_BASE_RST  = 32'h0010_0000;
   localparam logic [31:0] HEAP_LIMIT_RST = 32'h0020_0000;

   localparam logic [1:0] CSR_HEAP_BASE  = 2'd0;
   localparam logic [1:0] CSR_HEAP_LIMIT = 2'd1;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] STAT_ALLOCATED = 2'd0;
   localparam logic [1:0] STAT_NO_FIT    = 2'd1;
   localparam logic [1:0] STAT_RELEASED  = 2'd2;
   localparam logic [1:0] STAT_IGNORED   = 2'd3;

   typedef struct packed {
      logic        free;
      logic [31:0] bytes;
      logic [31:0] offset;
   } blk_type;

   typedef enum logic [1:0] {
      CHK_NEXT,
      CHK_TAKE,
      CHK_SPLIT,
      CHK_MATCH
   } chk_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_INIT,
      CMD_LOAD,
      CMD_FAIL,
      CMD_SCAN_RD,
      CMD_NEXT,
      CMD_TAKE,
      CMD_SPLIT_BEGIN,
      CMD_SH_RD,
      CMD_SH_WR,
      CMD_SPL_A,
      CMD_SPL_B,
      CMD_MATCH,
      CMD_M_RD,
      CMD_M_CHK,
      CMD_M_END,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      chk_type chk;
      logic    scan_end;
      logic    rel_bad;
      logic    shift_done;
   } dp_stat_type;

endpackage

@@ rtl/ffha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/ffha_dp.sv @@
// Datapath of the heap allocator: heap registers, block table RAM, scan/shift/merge
// pointers, and result registers. Uses ffha_pkg and ffha_ram.
module ffha_dp #(
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  logic                  req_op,
   input  logic [31:0]           req_req_bytes,
   input  logic [31:0]           req_release_addr,
   input  ffha_pkg::cmd_type     cmd,
   output ffha_pkg::dp_stat_type stat,
   output logic [31:0]           rsp_grant_addr,
   output logic [1:0]            rsp_status
);
   import ffha_pkg::*;

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [31:0] HB = 32'(HEADER_BYTES);
   localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
   localparam logic [CW-1:0] ONE = CW'(1);

   logic [31:0]   base_ff, base_in, limit_ff, limit_in;
   logic          op_ff, op_in;
   logic [31:0]   want_ff, want_in, rel_ff, rel_in;
   logic [CW-1:0] idx_ff, idx_in, sp_ff, sp_in, cnt_ff, cnt_in, match_ff, match_in;
   blk_type       hit_ff, hit_in, acc_ff, acc_in;
   logic [31:0]   res_grant_ff, res_grant_in, out_grant_ff, out_grant_in;
   logic [1:0]    res_status_ff, res_status_in, out_status_ff, out_status_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   blk_type       ram_wdata, rd, ent;
   logic [$bits(blk_type)-1:0] ram_rdata;

   logic [31:0] payload, span, size0;
   logic        fit;

   ffha_ram #(.WIDTH($bits(blk_type)), .DEPTH(MAX_BLOCKS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      rd      = blk_type'(ram_rdata);
      payload = base_ff + rd.offset + HB;
      fit     = {1'b0, rd.bytes} >= ({1'b0, want_ff} + {1'b0, HB});
      span    = limit_ff - base_ff;
      size0   = ((limit_ff > base_ff) && (span > HB)) ? (span - HB) : 32'd0;
      ent     = rd;
      ent.free = rd.free | (idx_ff == match_ff);

      stat.scan_end   = idx_ff >= cnt_ff;
      stat.rel_bad    = (op_ff == OP_RELEASE) &&
                        ((rel_ff < base_ff) || (rel_ff > limit_ff));
      stat.shift_done = {1'b0, sp_ff} <= ({1'b0, idx_ff} + {1'b0, ONE});
      stat.chk        = CHK_NEXT;
      if (op_ff == OP_ALLOC) begin
         if (rd.free && (rd.bytes == want_ff)) begin
            stat.chk = CHK_TAKE;
         end else if (rd.free && fit && (cnt_ff < MAXC)) begin
            stat.chk = CHK_SPLIT;
         end else if (rd.free && (rd.bytes > want_ff)) begin
            stat.chk = CHK_TAKE;
         end
      end else if (payload == rel_ff) begin
         stat.chk = CHK_MATCH;
      end
   end

   always_comb begin
      base_in       = base_ff;
      limit_in      = limit_ff;
      op_in         = op_ff;
      want_in       = want_ff;
      rel_in        = rel_ff;
      idx_in        = idx_ff;
      sp_in         = sp_ff;
      cnt_in        = cnt_ff;
      match_in      = match_ff;
      hit_in        = hit_ff;
      acc_in        = acc_ff;
      res_grant_in  = res_grant_ff;
      res_status_in = res_status_ff;
      out_grant_in  = out_grant_ff;
      out_status_in = out_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[AW-1:0];
      ram_wdata     = rd;
      ram_raddr     = idx_ff[AW-1:0];

      if (csr_wr_en) begin
         case (csr_index)
            CSR_HEAP_BASE:  base_in  = csr_wdata;
            CSR_HEAP_LIMIT: limit_in = csr_wdata;
            default: ;
         endcase
      end

      case (cmd)
         CMD_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '{free: 1'b1, bytes: size0, offset: 32'd0};
            cnt_in    = ONE;
         end
         CMD_LOAD: begin
            op_in   = req_op;
            want_in = req_req_bytes;
            rel_in  = req_release_addr;
            idx_in  = '0;
         end
         CMD_FAIL: begin
            res_grant_in  = 32'd0;
            res_status_in = (op_ff == OP_RELEASE) ? STAT_IGNORED : STAT_NO_FIT;
         end
         CMD_SCAN_RD, CMD_M_RD: ram_raddr = idx_ff[AW-1:0];
         CMD_NEXT: idx_in = idx_ff + ONE;
         CMD_TAKE: begin
            ram_we        = 1'b1;
            ram_wdata     = '{free: 1'b0, bytes: rd.bytes, offset: rd.offset};
            res_grant_in  = payload;
            res_status_in = STAT_ALLOCATED;
         end
         CMD_SPLIT_BEGIN: begin
            hit_in = rd;
            sp_in  = cnt_ff;
         end
         CMD_SH_RD: ram_raddr = AW'(sp_ff - ONE);
         CMD_SH_WR: begin
            ram_we    = 1'b1;
            ram_waddr = sp_ff[AW-1:0];
            ram_wdata = rd;
            sp_in     = sp_ff - ONE;
         end
         CMD_SPL_A: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(idx_ff + ONE);
            ram_wdata = '{free: 1'b1, bytes: hit_ff.bytes - want_ff - HB,
                          offset: hit_ff.offset + HB + want_ff};
         end
         CMD_SPL_B: begin
            ram_we        = 1'b1;
            ram_wdata     = '{free: 1'b0, bytes: want_ff, offset: hit_ff.offset};
            cnt_in        = cnt_ff + ONE;
            res_grant_in  = base_ff + hit_ff.offset + HB;
            res_status_in = STAT_ALLOCATED;
         end
         CMD_MATCH: begin
            match_in = idx_ff;
            idx_in   = '0;
            sp_in    = '0;
         end
         CMD_M_CHK: begin
            // coalesce runs of free blocks into the accumulator, flush otherwise
            if (idx_ff == '0) begin
               acc_in = ent;
            end else if (acc_ff.free && ent.free) begin
               acc_in.bytes = acc_ff.bytes + ent.bytes + HB;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = sp_ff[AW-1:0];
               ram_wdata = acc_ff;
               sp_in     = sp_ff + ONE;
               acc_in    = ent;
            end
            idx_in = idx_ff + ONE;
         end
         CMD_M_END: begin
            ram_we        = 1'b1;
            ram_waddr     = sp_ff[AW-1:0];
            ram_wdata     = acc_ff;
            cnt_in        = sp_ff + ONE;
            res_grant_in  = 32'd0;
            res_status_in = STAT_RELEASED;
         end
         CMD_EMIT: begin
            out_grant_in  = res_grant_ff;
            out_status_in = res_status_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= HEAP_BASE_RST;
         limit_ff <= HEAP_LIMIT_RST;
         cnt_ff   <= ONE;
         idx_ff   <= '0;
         sp_ff    <= '0;
         match_ff <= '0;
      end else begin
         base_ff  <= base_in;
         limit_ff <= limit_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         sp_ff    <= sp_in;
         match_ff <= match_in;
      end
      op_ff         <= op_in;
      want_ff       <= want_in;
      rel_ff        <= rel_in;
      hit_ff        <= hit_in;
      acc_ff        <= acc_in;
      res_grant_ff  <= res_grant_in;
      res_status_ff <= res_status_in;
      out_grant_ff  <= out_grant_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_grant_addr = out_grant_ff;
   assign rsp_status     = out_status_ff;
endmodule

@@ rtl/ffha_ctrl.sv @@
// Controller state machine of the heap allocator: sequences scan, split shift
// and merge passes, and owns the handshakes. Uses ffha_pkg.
module ffha_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  ffha_pkg::dp_stat_type stat,
   output ffha_pkg::cmd_type     cmd
);
   import ffha_pkg::*;

   typedef enum logic [9:0] {
      ST_INIT     = 10'b00_0000_0001,
      ST_IDLE     = 10'b00_0000_0010,
      ST_SCAN_RD  = 10'b00_0000_0100,
      ST_SCAN_CHK = 10'b00_0000_1000,
      ST_SH_RD    = 10'b00_0001_0000,
      ST_SH_WR    = 10'b00_0010_0000,
      ST_SPL_B    = 10'b00_0100_0000,
      ST_M_RD     = 10'b00_1000_0000,
      ST_M_CHK    = 10'b01_0000_0000,
      ST_DONE     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      csr_hit;

   // only writes to a defined register rebuild the table
   assign csr_hit = csr_wr_en && (csr_index inside {CSR_HEAP_BASE, CSR_HEAP_LIMIT});

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd = CMD_INIT;
            if (!csr_hit) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = !csr_hit;
            if (csr_hit) begin
               state_in = ST_INIT;
            end else if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (stat.scan_end || stat.rel_bad) begin
               cmd      = CMD_FAIL;
               state_in = ST_DONE;
            end else begin
               cmd      = CMD_SCAN_RD;
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            case (stat.chk)
               CHK_TAKE: begin
                  cmd      = CMD_TAKE;
                  state_in = ST_DONE;
               end
               CHK_SPLIT: begin
                  cmd      = CMD_SPLIT_BEGIN;
                  state_in = ST_SH_RD;
               end
               CHK_MATCH: begin
                  cmd      = CMD_MATCH;
                  state_in = ST_M_RD;
               end
               default: begin
                  cmd      = CMD_NEXT;
                  state_in = ST_SCAN_RD;
               end
            endcase
         end
         ST_SH_RD: begin
            if (stat.shift_done) begin
               cmd      = CMD_SPL_A;
               state_in = ST_SPL_B;
            end else begin
               cmd      = CMD_SH_RD;
               state_in = ST_SH_WR;
            end
         end
         ST_SH_WR: begin
            cmd      = CMD_SH_WR;
            state_in = ST_SH_RD;
         end
         ST_SPL_B: begin
            cmd      = CMD_SPL_B;
            state_in = ST_DONE;
         end
         ST_M_RD: begin
            if (stat.scan_end) begin
               cmd      = CMD_M_END;
               state_in = ST_DONE;
            end else begin
               cmd      = CMD_M_RD;
               state_in = ST_M_CHK;
            end
         end
         ST_M_CHK: begin
            cmd      = CMD_M_CHK;
            state_in = ST_M_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd      = CMD_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd == CMD_EMIT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

@@ rtl/first_fit_heap_allocator_core.sv @@
// Top level of the first-fit heap allocator with coalescing.
// Joins ffha_ctrl and ffha_dp. Uses ffha_pkg.
//
//   channel | handshake            | word
//   req     | req_valid/req_ready  | req_op, req_req_bytes, req_release_addr
//   rsp     | rsp_valid/rsp_ready  | rsp_grant_addr, rsp_status
//   csr     | csr_wr_en            | csr_index, csr_wdata
//
// One word at a time; the table RAM port is walked entry by entry.
// Alloc: scan; on a split, shift later entries up one, then write both halves.
// Release: scan entries to the match, then a merge pass over the whole table.
// The table is rebuilt after reset and after a base/limit csr write while idle.
// A finished word waits in the output register; a new req is taken meanwhile.
module first_fit_heap_allocator_core #(
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_req_bytes,
   input  logic [31:0] req_release_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_grant_addr,
   output logic [1:0]  rsp_status
);
   import ffha_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffha_dp #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_op           (req_op),
      .req_req_bytes    (req_req_bytes),
      .req_release_addr (req_release_addr),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_grant_addr   (rsp_grant_addr),
      .rsp_status       (rsp_status)
   );
endmodule

@@ rtl/ffha_checker.sv @@
// Port-level checks for first_fit_heap_allocator_core, bound to the top level.
// Uses ffha_pkg.
module ffha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_grant_addr,
   input logic [1:0]  rsp_status
);
   import ffha_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_grant_addr) && $stable(rsp_status))
      else $error("rsp word changed while stalled");

   a_zero_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_NO_FIT || rsp_status == STAT_RELEASED ||
                    rsp_status == STAT_IGNORED) |-> rsp_grant_addr == 32'd0)
      else $error("nonzero grant address without allocation");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while busy");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");
endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (.*);
